// ===== design/dvms_pkg.sv =====
// ----------------------------------------------------------------------------
// dvms_pkg
// shared types and constants of the dotted version maximum scanner
// ----------------------------------------------------------------------------
package dvms_pkg;

  localparam int NUM_PARTS     = 4;
  localparam int OUT_PART_BITS = 16;
  localparam int CHAR_BITS     = 16;
  localparam int LEN_BITS      = 8;
  localparam int LIMIT_BITS    = 8;

  localparam logic [CHAR_BITS-1:0] CH_DASH = 16'h002D;
  localparam logic [CHAR_BITS-1:0] CH_DOT  = 16'h002E;
  localparam logic [CHAR_BITS-1:0] CH_ZERO = 16'h0030;
  localparam logic [CHAR_BITS-1:0] CH_NINE = 16'h0039;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 8'd40;
  localparam logic [LEN_BITS-1:0]   LEN_SAT     = 8'hFF;
  localparam logic [1:0]            DOT_LAST    = 2'd3;

  // classified character
  typedef enum logic [1:0] {
    TK_OTHER,
    TK_DIGIT,
    TK_DOT,
    TK_DASH
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [3:0] digit;
    logic       last;
  } tok_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0] char_code;
    logic                 last;
  } in_item_t;

  typedef struct packed {
    logic                     found;
    logic [OUT_PART_BITS-1:0] major_part;
    logic [OUT_PART_BITS-1:0] minor_part;
    logic [OUT_PART_BITS-1:0] patch_part;
    logic [OUT_PART_BITS-1:0] build_part;
  } out_item_t;

  typedef enum logic [1:0] {
    MS_IDLE,
    MS_NEED_DIGIT,
    MS_DIGITS
  } match_state_t;

  typedef struct packed {
    logic open;
    logic add;
    logic count;
    logic dot;
    logic finish;
  } match_act_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ===== design/dvms_ifs.sv =====
// ----------------------------------------------------------------------------
// dvms channel interfaces
// valid/ready channels for characters, results and the limit register
// ----------------------------------------------------------------------------
interface dvms_in_if import dvms_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dvms_out_if import dvms_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dvms_cfg_if import dvms_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [LIMIT_BITS-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/dvms_front.sv =====
// ----------------------------------------------------------------------------
// dvms_front
// accepts characters and classifies them into tokens for the queue
// ----------------------------------------------------------------------------
module dvms_front import dvms_pkg::*; (
  dvms_in_if.sink    in_ch,
  input  queue_stat_t q_stat,
  output logic        push,
  output tok_t        push_tok
);

  logic [CHAR_BITS-1:0] c;
  logic [CHAR_BITS-1:0] c_off;

  assign c     = in_ch.data.char_code;
  assign c_off = c - CH_ZERO;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

  always_comb begin
    push_tok.last  = in_ch.data.last;
    push_tok.digit = c_off[3:0];
    if (c >= CH_ZERO && c <= CH_NINE) begin
      push_tok.kind = TK_DIGIT;
    end else if (c == CH_DOT) begin
      push_tok.kind = TK_DOT;
    end else if (c == CH_DASH) begin
      push_tok.kind = TK_DASH;
    end else begin
      push_tok.kind = TK_OTHER;
    end
  end

endmodule

// ===== design/dvms_queue.sv =====
// ----------------------------------------------------------------------------
// dvms_queue
// short token queue between the front and the back
// ----------------------------------------------------------------------------
module dvms_queue import dvms_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  tok_t        push_tok,
  input  logic        pop,
  output tok_t        head_tok,
  output queue_stat_t q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tok_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      ptr_inc = '0;
    end else begin
      ptr_inc = p + 1'b1;
    end
  endfunction

  assign head_tok     = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

// ===== design/dvms_back.sv =====
// ----------------------------------------------------------------------------
// dvms_back
// match engine, best version tracking, limit register and result register
// ----------------------------------------------------------------------------
module dvms_back import dvms_pkg::*; #(
  parameter int PART_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  dvms_cfg_if.sink     cfg_ch,
  dvms_out_if.source   out_ch,
  input  tok_t         tok,
  input  queue_stat_t  q_stat,
  output logic         pop
);

  localparam int WIDE_BITS = PART_BITS + 4;

  typedef logic [0:NUM_PARTS-1][PART_BITS-1:0] parts_t;

  match_state_t          state_r, state_nxt;
  match_act_t            act;
  logic [1:0]            dot_r, dot_nxt;
  logic [LEN_BITS-1:0]   len_r, len_nxt;
  parts_t                cur_r, cur_nxt;
  parts_t                best_r, best_nxt, best_upd;
  logic                  best_valid_r, best_valid_nxt, best_valid_upd;
  logic [LIMIT_BITS-1:0] limit_r;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic [PART_BITS-1:0]  cur_sel;
  logic [WIDE_BITS-1:0]  acc;
  logic [PART_BITS-1:0]  acc_sat;
  logic                  len_ok;

  // a last token must not overwrite a result still waiting
  assign pop = !q_stat.empty && (!tok.last || !out_valid_r || out_ch.ready);

  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    if (pop) begin
      case (state_r)
        MS_IDLE: begin
          if (tok.kind == TK_DASH) state_nxt = MS_NEED_DIGIT;
        end
        MS_NEED_DIGIT: begin
          state_nxt = (tok.kind == TK_DIGIT) ? MS_DIGITS : MS_IDLE;
        end
        MS_DIGITS: begin
          if (tok.kind == TK_DIGIT) begin
            state_nxt = MS_DIGITS;
          end else if (dot_r != DOT_LAST && tok.kind == TK_DOT) begin
            state_nxt = MS_NEED_DIGIT;
          end else begin
            state_nxt = MS_IDLE;
          end
        end
        default: state_nxt = MS_IDLE;
      endcase
      if (tok.last) state_nxt = MS_IDLE;
    end
  end

  // actions
  always_comb begin
    act = '0;
    if (pop) begin
      case (state_r)
        MS_IDLE: begin
          act.open = (tok.kind == TK_DASH);
        end
        MS_NEED_DIGIT: begin
          act.add   = (tok.kind == TK_DIGIT);
          act.count = (tok.kind == TK_DIGIT);
        end
        MS_DIGITS: begin
          if (tok.kind == TK_DIGIT) begin
            act.add   = 1'b1;
            act.count = 1'b1;
          end else if (dot_r == DOT_LAST) begin
            act.finish = 1'b1;
          end else if (tok.kind == TK_DOT) begin
            act.dot   = 1'b1;
            act.count = 1'b1;
          end
        end
        default: act = '0;
      endcase
    end
  end

  // datapath
  always_comb begin
    cur_sel = cur_r[dot_r];
    acc     = WIDE_BITS'({cur_sel, 3'b000}) + WIDE_BITS'({cur_sel, 1'b0})
            + WIDE_BITS'(tok.digit);
    acc_sat = (acc[WIDE_BITS-1:PART_BITS] != '0) ? '1 : acc[PART_BITS-1:0];
    len_ok  = (len_r != LEN_SAT) && (len_r <= limit_r);

    dot_nxt = dot_r;
    len_nxt = len_r;
    cur_nxt = cur_r;
    if (act.open) begin
      dot_nxt = '0;
      len_nxt = '0;
      cur_nxt = '0;
    end
    if (act.add) cur_nxt[dot_r] = acc_sat;
    if (act.dot) dot_nxt = dot_r + 1'b1;
    if (act.count && len_r != LEN_SAT) len_nxt = len_r + 1'b1;

    best_upd       = best_r;
    best_valid_upd = best_valid_r;
    if (act.finish && len_ok && (!best_valid_r || cur_r > best_r)) begin
      best_upd       = cur_r;
      best_valid_upd = 1'b1;
    end

    best_nxt       = best_upd;
    best_valid_nxt = best_valid_upd;

    out_data_nxt.found      = best_valid_upd;
    out_data_nxt.major_part = best_valid_upd ? OUT_PART_BITS'(best_upd[0]) : '0;
    out_data_nxt.minor_part = best_valid_upd ? OUT_PART_BITS'(best_upd[1]) : '0;
    out_data_nxt.patch_part = best_valid_upd ? OUT_PART_BITS'(best_upd[2]) : '0;
    out_data_nxt.build_part = best_valid_upd ? OUT_PART_BITS'(best_upd[3]) : '0;

    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (pop && tok.last) begin
      out_valid_nxt  = 1'b1;
      dot_nxt        = '0;
      len_nxt        = '0;
      cur_nxt        = '0;
      best_nxt       = '0;
      best_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= MS_IDLE;
      dot_r        <= '0;
      len_r        <= '0;
      cur_r        <= '0;
      best_r       <= '0;
      best_valid_r <= 1'b0;
      limit_r      <= LIMIT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      dot_r        <= dot_nxt;
      len_r        <= len_nxt;
      cur_r        <= cur_nxt;
      best_r       <= best_nxt;
      best_valid_r <= best_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_ch.valid) limit_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && tok.last) out_data_r <= out_data_nxt;
  end

endmodule

// ===== design/dotted_version_max_scanner.sv =====
// ----------------------------------------------------------------------------
// dotted_version_max_scanner
// finds the greatest dash-prefixed four-part dotted version in a text stream
// ----------------------------------------------------------------------------
// usage
//   in_ch  : one character per cycle while ready, char_code plus last flag
//   out_ch : one result transaction per text, issued after the last character
//   cfg_ch : writes max_match_length, always ready, write only while idle
// flow
//   a character is classified by the front, registered in the token queue and
//   handled by the back from there; the result register turns valid once the
//   back has handled the last character and holds until it is taken
// throughput
//   one character per cycle while no last character is held, set by the match
//   update (one times-ten accumulate and one four-part compare in the back)
// reset
//   rst_n clears the match state, the best version, the queue and the result
//   valid flag; the limit returns to 40
// stalls
//   while a result waits, characters keep flowing; a last character waits in
//   the queue until the result is taken, and in_ch.ready drops once it fills
// ----------------------------------------------------------------------------
module dotted_version_max_scanner import dvms_pkg::*; #(
  parameter int PART_BITS   = 16,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  dvms_in_if.sink     in_ch,
  dvms_out_if.source  out_ch,
  dvms_cfg_if.sink    cfg_ch
);

  // front to queue
  logic        q_push;
  tok_t        q_push_tok;
  // queue to back
  tok_t        head_tok;
  queue_stat_t q_stat;
  logic        back_pop;

  // classification of incoming characters
  dvms_front u_front (
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (q_push),
    .push_tok (q_push_tok)
  );

  // decouples the front from a stalled back
  dvms_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_tok (q_push_tok),
    .pop      (back_pop),
    .head_tok (head_tok),
    .q_stat   (q_stat)
  );

  // match engine and result register
  dvms_back #(
    .PART_BITS (PART_BITS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch),
    .tok    (head_tok),
    .q_stat (q_stat),
    .pop    (back_pop)
  );

  // the back never takes a token from an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    back_pop |-> !q_stat.empty)
    else $error("token popped from empty queue");

  // handling the last character always produces a result
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    back_pop && head_tok.last |=> out_ch.valid)
    else $error("last character gave no result");

  // with nothing found every part reads zero
  a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.data.found |->
      out_ch.data.major_part == '0 && out_ch.data.minor_part == '0 &&
      out_ch.data.patch_part == '0 && out_ch.data.build_part == '0)
    else $error("empty result carries nonzero parts");

endmodule
